@@ rtl/mcft_pkg.sv @@
// Shared types and constants for motor_current_from_torque.
// No dependencies; every other file in rtl/ uses this package.
`default_nettype none
package mcft_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int NUM_W          = 64;  // numerator, wraps like a 64-bit integer
  localparam int DEN_W          = 33;  // G*K plus or minus mu*G*K
  localparam int CFG_AW         = 5;
  localparam int NUM_LANES      = 3;
  localparam int LANE_POS       = 0;
  localparam int LANE_NEG       = 1;
  localparam int LANE_GK        = 2;

  localparam logic [23:0] TORQUE_CONST_RST = 24'd301990;
  localparam logic [31:0] VISC_FRIC_RST    = 32'd0;
  localparam logic [31:0] COUL_FRIC_RST    = 32'd167772;
  localparam logic [15:0] CUR_FRIC_RST     = 16'd6554;
  localparam logic [31:0] ROTOR_INERT_RST  = 32'd6872;
  localparam logic [7:0]  HIP_GEAR_RST     = 8'd66;
  localparam logic [7:0]  ANKLE_GEAR_RST   = 8'd34;

  typedef enum logic [2:0] {
    REG_TORQUE_CONST = 3'd0,
    REG_VISC_FRIC    = 3'd1,
    REG_COUL_FRIC    = 3'd2,
    REG_CUR_FRIC     = 3'd3,
    REG_ROTOR_INERT  = 3'd4,
    REG_HIP_GEAR     = 3'd5,
    REG_ANKLE_GEAR   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [23:0] torque_constant;
    logic [31:0] viscous_friction;
    logic [31:0] coulomb_friction;
    logic [15:0] current_friction_ratio;
    logic [31:0] rotor_inertia;
    logic [7:0]  hip_gear_ratio;
    logic [7:0]  ankle_gear_ratio;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/mcft_in_if.sv @@
// Input channel: joint select, rate, acceleration and torque.
// Depends on mcft_pkg for the default width.
`default_nettype none
interface mcft_in_if #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 joint_select;
  logic signed [DW-1:0] joint_rate;
  logic signed [DW-1:0] joint_accel;
  logic signed [DW-1:0] desired_torque;

  modport source (output valid, joint_select, joint_rate, joint_accel, desired_torque,
                  input ready);
  modport sink   (input valid, joint_select, joint_rate, joint_accel, desired_torque,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/mcft_out_if.sv @@
// Result channel: motor current with fallback and fault flags.
// Depends on mcft_pkg for the default width.
`default_nettype none
interface mcft_out_if #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] motor_current;
  logic                 fallback_used;
  logic                 divide_fault;

  modport source (output valid, motor_current, fallback_used, divide_fault, input ready);
  modport sink   (input valid, motor_current, fallback_used, divide_fault, output ready);
endinterface
`default_nettype wire

@@ rtl/mcft_cfg_regs.sv @@
// APB configuration registers, one per 32-bit word.
// Depends on mcft_pkg (cfg_t, register indexes, reset values).
`default_nettype none
module mcft_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mcft_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output mcft_pkg::cfg_t                    cfg
);

  mcft_pkg::cfg_t     cfg_r;
  mcft_pkg::reg_idx_t idx;

  assign idx    = mcft_pkg::reg_idx_t'(paddr[4:2]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.torque_constant        <= mcft_pkg::TORQUE_CONST_RST;
      cfg_r.viscous_friction       <= mcft_pkg::VISC_FRIC_RST;
      cfg_r.coulomb_friction       <= mcft_pkg::COUL_FRIC_RST;
      cfg_r.current_friction_ratio <= mcft_pkg::CUR_FRIC_RST;
      cfg_r.rotor_inertia          <= mcft_pkg::ROTOR_INERT_RST;
      cfg_r.hip_gear_ratio         <= mcft_pkg::HIP_GEAR_RST;
      cfg_r.ankle_gear_ratio       <= mcft_pkg::ANKLE_GEAR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        mcft_pkg::REG_TORQUE_CONST: cfg_r.torque_constant        <= pwdata[23:0];
        mcft_pkg::REG_VISC_FRIC:    cfg_r.viscous_friction       <= pwdata;
        mcft_pkg::REG_COUL_FRIC:    cfg_r.coulomb_friction       <= pwdata;
        mcft_pkg::REG_CUR_FRIC:     cfg_r.current_friction_ratio <= pwdata[15:0];
        mcft_pkg::REG_ROTOR_INERT:  cfg_r.rotor_inertia          <= pwdata;
        mcft_pkg::REG_HIP_GEAR:     cfg_r.hip_gear_ratio         <= pwdata[7:0];
        mcft_pkg::REG_ANKLE_GEAR:   cfg_r.ankle_gear_ratio       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mcft_pkg::REG_TORQUE_CONST: prdata = {8'b0, cfg_r.torque_constant};
      mcft_pkg::REG_VISC_FRIC:    prdata = cfg_r.viscous_friction;
      mcft_pkg::REG_COUL_FRIC:    prdata = cfg_r.coulomb_friction;
      mcft_pkg::REG_CUR_FRIC:     prdata = {16'b0, cfg_r.current_friction_ratio};
      mcft_pkg::REG_ROTOR_INERT:  prdata = cfg_r.rotor_inertia;
      mcft_pkg::REG_HIP_GEAR:     prdata = {24'b0, cfg_r.hip_gear_ratio};
      mcft_pkg::REG_ANKLE_GEAR:   prdata = {24'b0, cfg_r.ankle_gear_ratio};
      default:                    prdata = 32'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mcft_numer.sv @@
// Seven-stage front end: numerator magnitude and sign, and the three divisors.
// Depends on mcft_pkg (cfg_t, widths, lane indexes).
`default_nettype none
module mcft_numer #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic                          in_sel,
  input  wire logic [DW-1:0]                 in_rate,
  input  wire logic [DW-1:0]                 in_accel,
  input  wire logic [DW-1:0]                 in_torque,
  input  mcft_pkg::cfg_t                     cfg,
  output logic                               num_v,
  output logic [mcft_pkg::NUM_W-1:0]         num_mag,
  output logic                               num_neg,
  output logic [mcft_pkg::DEN_W-1:0]         den [mcft_pkg::NUM_LANES]
);

  localparam int NW = mcft_pkg::NUM_W;
  localparam int DNW = mcft_pkg::DEN_W;

  // stage 1: captured transaction
  logic                 s1_v_r, s1_sel_r;
  logic [DW-1:0]        s1_rate_r, s1_accel_r, s1_torque_r;
  // stage 2
  logic                 s2_v_r, s2_aneg_r, s2_wneg_r, s2_wzero_r;
  logic [15:0]          s2_g2_r;
  logic [31:0]          s2_gk_r, s2_amag_r, s2_wmag_r;
  logic signed [DW-1:0] s2_t_r;
  // stage 3
  logic                 s3_v_r, s3_aneg_r, s3_wneg_r, s3_wzero_r;
  logic [47:0]          s3_p_r, s3_visc_r;
  logic [31:0]          s3_gk_r, s3_mgk_r, s3_amag_r;
  logic signed [DW-1:0] s3_t_r;
  // stage 4
  logic                 s4_v_r, s4_aneg_r, s4_dpos_r, s4_dneg_r;
  logic [47:0]          s4_pph_r;
  logic [63:0]          s4_ppl_r;
  logic [NW-1:0]        s4_base_r;
  logic [DNW-1:0]       s4_den_r [mcft_pkg::NUM_LANES];
  // stage 5
  logic                 s5_v_r, s5_aneg_r;
  logic [NW-1:0]        s5_inert_r, s5_base_r;
  logic [DNW-1:0]       s5_den_r [mcft_pkg::NUM_LANES];
  // stage 6
  logic                 s6_v_r;
  logic [NW-1:0]        s6_num_r;
  logic [DNW-1:0]       s6_den_r [mcft_pkg::NUM_LANES];
  // stage 7
  logic                 s7_v_r, s7_neg_r;
  logic [NW-1:0]        s7_mag_r;
  logic [DNW-1:0]       s7_den_r [mcft_pkg::NUM_LANES];

  logic [7:0]     g;
  logic [DW-1:0]  amag_full, wmag_full;
  logic [DW+31:0] amag_ext, wmag_ext;
  logic [63:0]    visc_prod;
  logic [47:0]    mgk_prod;
  logic [NW-1:0]  t64, visc64, c64, base_nxt, inert_nxt, base2_nxt, num_nxt;
  logic [DNW-1:0] gk33, mgk33;

  assign g         = s1_sel_r ? cfg.ankle_gear_ratio : cfg.hip_gear_ratio;
  assign amag_full = s1_accel_r[DW-1] ? (~s1_accel_r + 1'b1) : s1_accel_r;
  assign wmag_full = s1_rate_r[DW-1] ? (~s1_rate_r + 1'b1) : s1_rate_r;
  assign amag_ext  = {32'b0, amag_full};
  assign wmag_ext  = {32'b0, wmag_full};

  assign visc_prod = {32'b0, cfg.viscous_friction} * {32'b0, s2_wmag_r};
  assign mgk_prod  = {32'b0, cfg.current_friction_ratio} * {16'b0, s2_gk_r};

  assign gk33   = {1'b0, s3_gk_r};
  assign mgk33  = {1'b0, s3_mgk_r};
  assign t64    = 64'(s3_t_r);
  assign visc64 = {16'b0, s3_visc_r};
  assign base_nxt = {t64[NW-9:0], 8'b0} + (s3_wneg_r ? (~visc64 + 1'b1) : visc64);

  assign inert_nxt = {8'b0, s4_pph_r, 8'b0} + {24'b0, s4_ppl_r[63:24]};
  assign c64       = {32'b0, cfg.coulomb_friction};
  always_comb begin
    base2_nxt = s4_base_r;
    if (s4_dpos_r) begin
      base2_nxt = s4_base_r + c64;
    end else if (s4_dneg_r) begin
      base2_nxt = s4_base_r - c64;
    end
  end

  assign num_nxt = s5_base_r + (s5_aneg_r ? (~s5_inert_r + 1'b1) : s5_inert_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sel_r    <= in_sel;
      s1_rate_r   <= in_rate;
      s1_accel_r  <= in_accel;
      s1_torque_r <= in_torque;

      s2_g2_r    <= {8'b0, g} * {8'b0, g};
      s2_gk_r    <= {24'b0, g} * {8'b0, cfg.torque_constant};
      s2_amag_r  <= amag_ext[31:0];
      s2_wmag_r  <= wmag_ext[31:0];
      s2_t_r     <= s1_torque_r;
      s2_aneg_r  <= s1_accel_r[DW-1];
      s2_wneg_r  <= s1_rate_r[DW-1];
      s2_wzero_r <= (s1_rate_r == '0);

      s3_p_r     <= {32'b0, s2_g2_r} * {16'b0, cfg.rotor_inertia};
      s3_mgk_r   <= mgk_prod[47:16];
      s3_visc_r  <= visc_prod[63:16];
      s3_gk_r    <= s2_gk_r;
      s3_amag_r  <= s2_amag_r;
      s3_t_r     <= s2_t_r;
      s3_aneg_r  <= s2_aneg_r;
      s3_wneg_r  <= s2_wneg_r;
      s3_wzero_r <= s2_wzero_r;

      s4_pph_r  <= {32'b0, s3_p_r[47:32]} * {16'b0, s3_amag_r};
      s4_ppl_r  <= {32'b0, s3_p_r[31:0]} * {32'b0, s3_amag_r};
      s4_base_r <= base_nxt;
      s4_aneg_r <= s3_aneg_r;
      s4_dpos_r <= !s3_wneg_r && !s3_wzero_r;
      s4_dneg_r <= s3_wneg_r;
      s4_den_r[mcft_pkg::LANE_GK] <= gk33;
      if (s3_wneg_r) begin
        s4_den_r[mcft_pkg::LANE_POS] <= gk33 + mgk33;
        s4_den_r[mcft_pkg::LANE_NEG] <= gk33 - mgk33;
      end else if (!s3_wzero_r) begin
        s4_den_r[mcft_pkg::LANE_POS] <= gk33 - mgk33;
        s4_den_r[mcft_pkg::LANE_NEG] <= gk33 + mgk33;
      end else begin
        s4_den_r[mcft_pkg::LANE_POS] <= gk33;
        s4_den_r[mcft_pkg::LANE_NEG] <= gk33;
      end

      s5_inert_r <= inert_nxt;
      s5_base_r  <= base2_nxt;
      s5_aneg_r  <= s4_aneg_r;
      s5_den_r   <= s4_den_r;

      s6_num_r <= num_nxt;
      s6_den_r <= s5_den_r;

      s7_mag_r <= s6_num_r[NW-1] ? (~s6_num_r + 1'b1) : s6_num_r;
      s7_neg_r <= s6_num_r[NW-1];
      s7_den_r <= s6_den_r;
    end
  end

  assign num_v   = s7_v_r;
  assign num_mag = s7_mag_r;
  assign num_neg = s7_neg_r;
  assign den     = s7_den_r;

endmodule
`default_nettype wire

@@ rtl/mcft_div_pipe.sv @@
// Restoring divider, one quotient bit per stage, three divisor lanes sharing one dividend.
// Quotient is |N|*2^16/D, saturated to the signed range and signed. Depends on mcft_pkg.
`default_nettype none
module mcft_div_pipe #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_v,
  input  wire logic [mcft_pkg::NUM_W-1:0]   in_mag,
  input  wire logic                         in_neg,
  input  wire logic [mcft_pkg::DEN_W-1:0]   in_den [mcft_pkg::NUM_LANES],
  output logic                              out_v,
  output logic      [DW-1:0]                out_res [mcft_pkg::NUM_LANES],
  output logic                              out_flt [mcft_pkg::NUM_LANES]
);

  localparam int  NL   = mcft_pkg::NUM_LANES;
  localparam int  DNW  = mcft_pkg::DEN_W;
  localparam bit  WIDE = (DW == 64);

  logic             v_r   [0:DW];
  logic             neg_r [0:DW];
  logic             nz_r  [0:DW];
  logic [DW-1:0]    xs_r  [0:DW];
  logic [DNW-1:0]   den_r [0:DW][NL];
  logic [DNW-1:0]   rem_r [0:DW][NL];
  logic [DW-1:0]    q_r   [0:DW][NL];
  logic             ovf_r [0:DW][NL];

  logic             fin_v_r;
  logic [DW-1:0]    fin_res_r [NL];
  logic             fin_flt_r [NL];

  logic [127:0]     x;
  logic [127:0]     mag128;
  logic [127:0]     den_sh [NL];

  assign x      = {48'b0, in_mag, 16'b0};
  assign mag128 = {64'b0, in_mag};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      den_sh[l] = {95'b0, in_den[l]} << (DW - 16);
    end
  end

  // entry stage: overflow test and top part of the dividend
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= in_neg;
      nz_r[0]  <= (in_mag != '0);
      xs_r[0]  <= x[DW-1:0];
      for (int l = 0; l < NL; l++) begin
        den_r[0][l] <= in_den[l];
        rem_r[0][l] <= x[DW+32 -: 33];
        q_r[0][l]   <= '0;
        ovf_r[0][l] <= (mag128 >= den_sh[l]);
      end
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic [DNW:0] trial [NL];
    logic [DNW:0] diff  [NL];
    logic         ge    [NL];

    always_comb begin
      for (int l = 0; l < NL; l++) begin
        trial[l] = {rem_r[k][l], xs_r[k][DW-1]};
        diff[l]  = trial[l] - {1'b0, den_r[k][l]};
        ge[l]    = (trial[l] >= {1'b0, den_r[k][l]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[k+1] <= neg_r[k];
        nz_r[k+1]  <= nz_r[k];
        xs_r[k+1]  <= {xs_r[k][DW-2:0], 1'b0};
        for (int l = 0; l < NL; l++) begin
          den_r[k+1][l] <= den_r[k][l];
          ovf_r[k+1][l] <= ovf_r[k][l];
          rem_r[k+1][l] <= ge[l] ? diff[l][DNW-1:0] : trial[l][DNW-1:0];
          q_r[k+1][l]   <= {q_r[k][l][DW-2:0], ge[l]};
        end
      end
    end
  end

  // saturation and sign
  logic [DW-1:0] lim;
  logic [DW-1:0] qm  [NL];
  logic          sat [NL];

  assign lim = neg_r[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      sat[l] = ovf_r[DW][l] || (q_r[DW][l] > lim) || (WIDE && q_r[DW][l][DW-1]);
      if (ovf_r[DW][l] && !nz_r[DW]) begin
        qm[l] = '0;
      end else if (sat[l]) begin
        qm[l] = lim;
      end else begin
        qm[l] = q_r[DW][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= v_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NL; l++) begin
        fin_res_r[l] <= neg_r[DW] ? (~qm[l] + 1'b1) : qm[l];
        fin_flt_r[l] <= sat[l];
      end
    end
  end

  assign out_v   = fin_v_r;
  assign out_res = fin_res_r;
  assign out_flt = fin_flt_r;

endmodule
`default_nettype wire

@@ rtl/mcft_out_buf.sv @@
// Quotient selection and output register with one skid entry.
// Depends on mcft_pkg and mcft_out_if.
`default_nettype none
module mcft_out_buf #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_v,
  input  wire logic [DW-1:0] up_res [mcft_pkg::NUM_LANES],
  input  wire logic          up_flt [mcft_pkg::NUM_LANES],
  output logic               up_ready,
  mcft_out_if.source         out_ch
);

  logic          pos_p, pos_n, up_acc;
  logic [DW-1:0] sel_cur;
  logic          sel_fb, sel_flt;

  logic          out_v_r, sk_v_r;
  logic [DW-1:0] out_cur_r, sk_cur_r;
  logic          out_fb_r, out_flt_r, sk_fb_r, sk_flt_r;

  assign pos_p = (up_res[mcft_pkg::LANE_POS] != '0) && !up_res[mcft_pkg::LANE_POS][DW-1];
  assign pos_n = (up_res[mcft_pkg::LANE_NEG] != '0) && !up_res[mcft_pkg::LANE_NEG][DW-1];

  always_comb begin
    priority if (pos_p && pos_n) begin
      sel_cur = up_res[mcft_pkg::LANE_POS];
      sel_flt = up_flt[mcft_pkg::LANE_POS];
      sel_fb  = 1'b0;
    end else if (!pos_p && !pos_n) begin
      sel_cur = up_res[mcft_pkg::LANE_NEG];
      sel_flt = up_flt[mcft_pkg::LANE_NEG];
      sel_fb  = 1'b0;
    end else begin
      sel_cur = up_res[mcft_pkg::LANE_GK];
      sel_flt = up_flt[mcft_pkg::LANE_GK];
      sel_fb  = 1'b1;
    end
  end

  assign up_ready = !sk_v_r;
  assign up_acc   = up_v && !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= up_acc;
      end
    end else if (up_acc) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      if (sk_v_r) begin
        out_cur_r <= sk_cur_r;
        out_fb_r  <= sk_fb_r;
        out_flt_r <= sk_flt_r;
      end else if (up_acc) begin
        out_cur_r <= sel_cur;
        out_fb_r  <= sel_fb;
        out_flt_r <= sel_flt;
      end
    end else if (up_acc) begin
      sk_cur_r <= sel_cur;
      sk_fb_r  <= sel_fb;
      sk_flt_r <= sel_flt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.motor_current = out_cur_r;
  assign out_ch.fallback_used = out_fb_r;
  assign out_ch.divide_fault  = out_flt_r;

endmodule
`default_nettype wire

@@ rtl/motor_current_from_torque.sv @@
// Top level: geared motor current from desired joint torque.
// Depends on mcft_pkg, mcft_in_if, mcft_out_if, mcft_cfg_regs, mcft_numer,
// mcft_div_pipe and mcft_out_buf.
//
//  channel  direction  handshake           payload
//  in_ch    sink       valid/ready         joint_select, joint_rate, joint_accel, desired_torque
//  out_ch   source     valid/ready         motor_current, fallback_used, divide_fault
//  cfg      APB slave  psel/penable/pready 7 registers at 4*index, 32-bit data
//
// One transaction per cycle, sustained while out_ch is not stalled. The pipeline depth
// grows with DATA_WIDTH, since the divider computes one quotient bit per stage.
// Synchronous active-low reset clears valid bits and loads register defaults; no clearing pass.
// A stall at out_ch fills one skid entry, then in_ch.ready drops; nothing is lost or repeated.
`default_nettype none
module motor_current_from_torque #(
  parameter int DATA_WIDTH = mcft_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mcft_in_if.sink                          in_ch,
  mcft_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mcft_pkg::CFG_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  mcft_pkg::cfg_t cfg;
  logic           en;
  logic           num_v, num_neg;
  logic [mcft_pkg::NUM_W-1:0] num_mag;
  logic [mcft_pkg::DEN_W-1:0] den [mcft_pkg::NUM_LANES];
  logic                       div_v;
  logic [DATA_WIDTH-1:0]      div_res [mcft_pkg::NUM_LANES];
  logic                       div_flt [mcft_pkg::NUM_LANES];

  assign in_ch.ready = en;

  mcft_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcft_numer #(.DW(DATA_WIDTH)) u_numer (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_sel    (in_ch.joint_select),
    .in_rate   (in_ch.joint_rate),
    .in_accel  (in_ch.joint_accel),
    .in_torque (in_ch.desired_torque),
    .cfg       (cfg),
    .num_v     (num_v),
    .num_mag   (num_mag),
    .num_neg   (num_neg),
    .den       (den)
  );

  mcft_div_pipe #(.DW(DATA_WIDTH)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (num_v),
    .in_mag  (num_mag),
    .in_neg  (num_neg),
    .in_den  (den),
    .out_v   (div_v),
    .out_res (div_res),
    .out_flt (div_flt)
  );

  mcft_out_buf #(.DW(DATA_WIDTH)) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_v     (div_v),
    .up_res   (div_res),
    .up_flt   (div_flt),
    .up_ready (en),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/mcft_checker.sv @@
// Port-level checks for motor_current_from_torque, bound to the top level.
// Depends on mcft_pkg for the default width and on the top level's ports.
`default_nettype none
module mcft_checker #(
  parameter int DW = mcft_pkg::DATA_WIDTH_DEF
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [DW-1:0] cur,
  input wire logic          fb,
  input wire logic          flt
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cur) && $stable(fb) && $stable(flt))
    else $error("result transaction changed while stalled");

  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready && in_valid) || $past(out_valid && !out_ready))
    else $error("input ready dropped without an output stall");

  a_full_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked while output register empty");

  a_fb_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fb |-> !cur[DW-1])
    else $error("fallback result is negative");

endmodule

bind motor_current_from_torque mcft_checker #(.DW(DATA_WIDTH)) u_mcft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cur       (out_ch.motor_current),
  .fb        (out_ch.fallback_used),
  .flt       (out_ch.divide_fault)
);
`default_nettype wire
